// ===== src/sitbd_pkg.sv =====
// sitbd_pkg: shared widths, character codes and register indexes for the
// signed integer to base digits converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sitbd_pkg;

    localparam int NUM_W       = 32;  // input number width
    localparam int SYM_W       = 8;   // one text byte
    localparam int DIGIT_W     = 5;   // digit value, radix <= 32
    localparam int LEN_W       = 6;   // base_length register width
    localparam int STACK_DEPTH = 32;  // max digits (radix 2, 32 bits)
    localparam int ALPHA_WORDS = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN   = 3'd4;

    typedef logic [NUM_W-1:0]        number_t;
    typedef logic [SYM_W-1:0]        symbol_t;
    typedef logic [DIGIT_W-1:0]      digit_t;
    typedef logic [LEN_W-1:0]        len_t;
    typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

endpackage

`default_nettype wire

// ===== src/sitbd_if.sv =====
// sitbd_if: valid/ready channels for input numbers and output symbols.
// Depends on sitbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sitbd_num_if;
    logic                    valid;
    logic                    ready;
    logic signed [sitbd_pkg::NUM_W-1:0] number;

    modport source  (output valid, output number, input ready);
    modport sink    (input valid, input number, output ready);
    modport monitor (input valid, input number, input ready);
endinterface

interface sitbd_sym_if;
    logic               valid;
    logic               ready;
    sitbd_pkg::symbol_t symbol;
    logic               is_last;

    modport source  (output valid, output symbol, output is_last, input ready);
    modport sink    (input valid, input symbol, input is_last, output ready);
    modport monitor (input valid, input symbol, input is_last, input ready);
endinterface

`default_nettype wire

// ===== src/signed_int_to_base_digits.sv =====
// signed_int_to_base_digits: renders a signed 32-bit number as text in a
// configurable alphabet, most significant symbol first.
// Depends on sitbd_pkg and sitbd_if.
//
//  channel   dir  payload                    accepted when
//  num_in    in   number[31:0] signed        valid && ready
//  sym_out   out  symbol[7:0], is_last       valid && ready
//  cfg_wr_*  in   index[2:0], data[63:0]     cfg_wr_en
//
// Per item, in order: one duplicate/sign check per alphabet symbol, then
// one restoring divider step per cycle for each digit, then the sign for
// a negative number, then one symbol per digit. An invalid alphabet gives
// no output. One item at a time; ready is high only in idle.
// Result register decouples output stalls; a stalled sym_out holds the
// sequencer. Reset clears control and config; the digit stack is not reset.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_base_digits #(
    parameter int MAX_SYMBOLS = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    sitbd_num_if.sink              num_in,
    sitbd_sym_if.source            sym_out,
    input  wire                    cfg_wr_en,
    input  wire sitbd_pkg::cfg_idx_t  cfg_wr_index,
    input  wire sitbd_pkg::cfg_data_t cfg_wr_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // configuration
    sitbd_pkg::cfg_data_t alpha_reg [sitbd_pkg::ALPHA_WORDS];
    sitbd_pkg::len_t      base_len_reg;
    logic [sitbd_pkg::STACK_DEPTH-1:0][sitbd_pkg::SYM_W-1:0] sym_tab;

    // sequencer
    logic [2:0]              state_reg, state_next;
    logic                    neg_reg, neg_next;
    logic [4:0]              idx_reg, idx_next;
    sitbd_pkg::number_t      quot_reg, quot_next;
    sitbd_pkg::digit_t       rem_reg, rem_next;
    logic [4:0]              step_reg, step_next;
    sitbd_pkg::len_t         count_reg, count_next;
    sitbd_pkg::digit_t       stack_reg [sitbd_pkg::STACK_DEPTH];

    // output register
    logic                    ov_reg, ov_next;
    sitbd_pkg::symbol_t      osym_reg, osym_next;
    logic                    olast_reg, olast_next;

    logic                    len_ok;
    sitbd_pkg::symbol_t      cur_sym;
    logic                    dup;
    logic [5:0]              trial;
    logic                    ge;
    sitbd_pkg::digit_t       rem_new;
    sitbd_pkg::number_t      quot_new;
    sitbd_pkg::number_t      raw;
    sitbd_pkg::len_t         pop_idx;
    logic                    slot_free;
    logic                    stack_we;

    function automatic sitbd_pkg::len_t pop_len(input sitbd_pkg::len_t len);
        pop_len = len - 6'd1;
    endfunction

    assign sym_tab = {alpha_reg[3], alpha_reg[2], alpha_reg[1], alpha_reg[0]};

    assign len_ok = (base_len_reg >= 6'd2) &&
                    (base_len_reg <= sitbd_pkg::len_t'(MAX_SYMBOLS));

    // symbol under check against every earlier symbol
    assign cur_sym = sym_tab[idx_reg];
    always_comb
    begin
        dup = 1'b0;
        for (int k = 0; k < sitbd_pkg::STACK_DEPTH; k++)
        begin
            if ((5'(k) < idx_reg) && (sym_tab[k] == cur_sym))
                dup = 1'b1;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign trial    = {rem_reg, quot_reg[sitbd_pkg::NUM_W-1]};
    assign ge       = (trial >= base_len_reg);
    assign rem_new  = ge ? 5'(trial - base_len_reg) : trial[4:0];
    assign quot_new = {quot_reg[sitbd_pkg::NUM_W-2:0], ge};

    assign raw       = $unsigned(num_in.number);
    assign pop_idx   = count_reg - 6'd1;
    assign slot_free = !ov_reg || sym_out.ready;

    assign num_in.ready    = (state_reg == ST_IDLE);
    assign sym_out.valid   = ov_reg;
    assign sym_out.symbol  = osym_reg;
    assign sym_out.is_last = olast_reg;

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        count_next = count_reg;
        stack_we   = 1'b0;
        ov_next    = sym_out.ready ? 1'b0 : ov_reg;
        osym_next  = osym_reg;
        olast_next = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (num_in.valid)
                begin
                    neg_next  = raw[sitbd_pkg::NUM_W-1];
                    quot_next = raw[sitbd_pkg::NUM_W-1] ? (32'd0 - raw) : raw;
                    idx_next  = 5'd0;
                    if (len_ok)
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (dup || (cur_sym inside {sitbd_pkg::CHAR_PLUS, sitbd_pkg::CHAR_MINUS}))
                begin
                    state_next = ST_IDLE;
                end
                else if ({1'b0, idx_reg} == pop_len(base_len_reg))
                begin
                    rem_next   = '0;
                    step_next  = '0;
                    count_next = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    idx_next = idx_reg + 5'd1;
                end
            end
            ST_DIV:
            begin
                quot_next = quot_new;
                rem_next  = rem_new;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    // digit done: push remainder, restart on quotient
                    stack_we   = 1'b1;
                    count_next = count_reg + 6'd1;
                    rem_next   = '0;
                    if (quot_new == '0 || count_reg == 6'd31)
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    osym_next  = sitbd_pkg::CHAR_MINUS;
                    olast_next = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    osym_next  = sym_tab[stack_reg[pop_idx[4:0]]];
                    olast_next = (pop_idx == '0);
                    count_next = pop_idx;
                    if (pop_idx == '0)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ov_reg       <= 1'b0;
            count_reg    <= '0;
            base_len_reg <= '0;
            for (int w = 0; w < sitbd_pkg::ALPHA_WORDS; w++)
                alpha_reg[w] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                case (cfg_wr_index)
                    sitbd_pkg::REG_ALPHABET_0: alpha_reg[0] <= cfg_wr_data;
                    sitbd_pkg::REG_ALPHABET_1: alpha_reg[1] <= cfg_wr_data;
                    sitbd_pkg::REG_ALPHABET_2: alpha_reg[2] <= cfg_wr_data;
                    sitbd_pkg::REG_ALPHABET_3: alpha_reg[3] <= cfg_wr_data;
                    sitbd_pkg::REG_BASE_LEN:
                        base_len_reg <= cfg_wr_data[sitbd_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        idx_reg   <= idx_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        osym_reg  <= osym_next;
        olast_reg <= olast_next;
        if (stack_we)
            stack_reg[count_reg[4:0]] <= rem_new;
    end

endmodule

`default_nettype wire

// ===== src/sitbd_checker.sv =====
// sitbd_checker: port-level assertions for signed_int_to_base_digits,
// attached by bind. Depends on sitbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitbd_checker (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     num_valid,
    input  wire                     num_ready,
    input  wire                     sym_valid,
    input  wire                     sym_ready,
    input  wire sitbd_pkg::symbol_t sym_symbol,
    input  wire                     sym_is_last
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_ready |=>
            sym_valid && $stable(sym_symbol) && $stable(sym_is_last))
        else $error("sym_out item changed while stalled");

    // the sign never ends a text
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_symbol == sitbd_pkg::CHAR_MINUS |-> !sym_is_last)
        else $error("minus sign flagged as last symbol");

    // when idle, only the final symbol of the previous number may be pending
    a_idle_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
        num_ready && sym_valid |-> sym_is_last)
        else $error("ready for a new number with text still unfinished");

    // no number is taken while a non-final symbol is still waiting
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && num_ready && sym_valid && !sym_is_last |-> 1'b0)
        else $error("number accepted while text still in flight");

endmodule

bind signed_int_to_base_digits sitbd_checker u_sitbd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .num_valid   (num_in.valid),
    .num_ready   (num_in.ready),
    .sym_valid   (sym_out.valid),
    .sym_ready   (sym_out.ready),
    .sym_symbol  (sym_out.symbol),
    .sym_is_last (sym_out.is_last)
);

`default_nettype wire
